/* rtl/lacp_transmit_state_machine_assert.svh */
// Assertion macros used by the transmit machine controller.
`ifndef LACP_TRANSMIT_STATE_MACHINE_ASSERT_SVH
`define LACP_TRANSMIT_STATE_MACHINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define LTSM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked on every rising clock edge outside reset.
`define LTSM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LTSM_ASSERT_NOW(label, ante, cons, msg)
`define LTSM_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* rtl/lacp_tsm_pkg.sv */
// Types and constants shared by the transmit machine controller, datapath and top level.
package lacp_tsm_pkg;

   // Item modes.
   localparam logic [1:0] MODE_EVAL  = 2'd0;
   localparam logic [1:0] MODE_TICK  = 2'd1;
   localparam logic [1:0] MODE_RESET = 2'd2;

   // Machine state codes as reported in the result.
   localparam logic [2:0] ST_NO_TX       = 3'd0;
   localparam logic [2:0] ST_RESET_COUNT = 3'd1;
   localparam logic [2:0] ST_TX_PDU      = 3'd2;
   localparam logic [2:0] ST_FAST        = 3'd3;
   localparam logic [2:0] ST_SLOW        = 3'd4;

   // Configuration register indexes.
   localparam logic [2:0] CSR_PROTOCOL_VERSION = 3'd0;
   localparam logic [2:0] CSR_TX_LIMIT         = 3'd1;
   localparam logic [2:0] CSR_LIMIT_INTERVAL   = 3'd2;
   localparam logic [2:0] CSR_FAST_PERIOD      = 3'd3;
   localparam logic [2:0] CSR_SLOW_PERIOD      = 3'd4;

   // Configuration reset values.
   localparam logic [1:0]  RST_PROTOCOL_VERSION = 2'd1;
   localparam logic [7:0]  RST_TX_LIMIT         = 8'd3;
   localparam logic [15:0] RST_LIMIT_INTERVAL   = 16'd1;
   localparam logic [15:0] RST_FAST_PERIOD      = 16'd1;
   localparam logic [15:0] RST_SLOW_PERIOD      = 16'd30;

   // The version 1 machine runs under this code; every other code selects version 2.
   localparam logic [1:0] PROTOCOL_V1 = 2'd1;

   localparam logic [7:0] SENT_MAX = 8'hFF;

   typedef struct packed {
      logic [1:0] mode;
      logic       single_step;
      logic       ntt_request;
      logic       tx_enabled;
      logic       port_up;
      logic       point_to_point;
      logic       actor_active;
      logic       partner_active;
      logic       partner_short_timeout;
      logic       mac_up;
   } item_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic exec;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] mode;
      logic       single;
      logic       fired;
      logic       trans_last;
   } status_type;

endpackage

/* rtl/lacp_transmit_state_machine.sv */
// Top level of the link aggregation control transmit machine for one port.
// A tick, reset or unused-mode item is applied in the exec state and then written out;
// an evaluation steps once per cycle until nothing fires, single step is asked for or the
// MAX_LOOP bound is reached, and its result is written once the result register is free.
// One item is in flight at a time; the next beat is taken once the result is registered.
// Synchronous reset restores the machine to no_tx and the configuration to its reset values.
module lacp_transmit_state_machine #(
   parameter int MAX_LOOP   = 10,
   parameter int TIMER_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,

   // Input item channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic        req_single_step,
   input  logic        req_ntt_request,
   input  logic        req_tx_enabled,
   input  logic        req_port_up,
   input  logic        req_point_to_point,
   input  logic        req_actor_active,
   input  logic        req_partner_active,
   input  logic        req_partner_short_timeout,
   input  logic        req_mac_up,

   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_machine_state,
   output logic [3:0]  rsp_transitions,
   output logic [3:0]  rsp_frames_sent,
   output logic        rsp_ntt_pending,
   output logic        rsp_tx_opportunity,

   // Configuration write port.
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // The controller only sequences: it accepts a beat, keeps the datapath stepping while
   // an evaluation still fires transitions, and then loads the result register once the
   // previous result beat has been taken. The output register lets the next beat be
   // accepted while a finished result is still waiting on the result channel.
   lacp_tsm_pkg::item_type   item;
   lacp_tsm_pkg::cmd_type    cmd;
   lacp_tsm_pkg::status_type status;

   assign item.mode                  = req_mode;
   assign item.single_step           = req_single_step;
   assign item.ntt_request           = req_ntt_request;
   assign item.tx_enabled            = req_tx_enabled;
   assign item.port_up               = req_port_up;
   assign item.point_to_point        = req_point_to_point;
   assign item.actor_active          = req_actor_active;
   assign item.partner_active        = req_partner_active;
   assign item.partner_short_timeout = req_partner_short_timeout;
   assign item.mac_up                = req_mac_up;

   lacp_tsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the configuration, the machine state with both timers, and the
   // single step unit that evaluates one transition and its entry actions per cycle.
   lacp_tsm_dp #(
      .MAX_LOOP   (MAX_LOOP),
      .TIMER_BITS (TIMER_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .item               (item),
      .cmd                (cmd),
      .status             (status),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_machine_state  (rsp_machine_state),
      .rsp_transitions    (rsp_transitions),
      .rsp_frames_sent    (rsp_frames_sent),
      .rsp_ntt_pending    (rsp_ntt_pending),
      .rsp_tx_opportunity (rsp_tx_opportunity)
   );

endmodule

/* rtl/lacp_tsm_ctrl.sv */
// Sequencer for the transmit machine: accepts an item, runs its steps, hands off the result.
`include "lacp_transmit_state_machine_assert.svh"

module lacp_tsm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  lacp_tsm_pkg::status_type  status,
   output lacp_tsm_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      CTL_IDLE  = 3'b001,
      CTL_EXEC  = 3'b010,
      CTL_WRITE = 3'b100
   } ctl_state_type;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != CTL_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         CTL_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            cmd.exec = 1'b1;
            // An evaluation keeps stepping until nothing fires, one step was asked for,
            // or the transition bound is reached.
            if ((status.mode != lacp_tsm_pkg::MODE_EVAL) || !status.fired ||
                status.single || status.trans_last) begin
               state_in = CTL_WRITE;
            end
         end
         CTL_WRITE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `LTSM_ASSERT_NOW(a_load_needs_room, cmd.load_out, out_free, "result loaded over a waiting beat")
   `LTSM_ASSERT_NEXT(a_accept_runs, req_valid && !req_stall, state_ff == CTL_EXEC, "accepted item not executed")
   `LTSM_ASSERT_NEXT(a_write_shows, (state_ff == CTL_WRITE) && out_free, rsp_valid_ff, "finished result not presented")
   `LTSM_ASSERT_NEXT(a_single_cycle_ops, (state_ff == CTL_EXEC) && (status.mode != lacp_tsm_pkg::MODE_EVAL), state_ff == CTL_WRITE, "tick or reset took more than one cycle")

endmodule

/* rtl/lacp_tsm_dp.sv */
// Datapath of the transmit machine: configuration, machine state, timers, step logic, result register.
module lacp_tsm_dp #(
   parameter int MAX_LOOP   = 10,
   parameter int TIMER_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lacp_tsm_pkg::item_type    item,
   input  lacp_tsm_pkg::cmd_type     cmd,
   output lacp_tsm_pkg::status_type  status,
   input  logic                      csr_write,
   input  logic [2:0]                csr_index,
   input  logic [15:0]               csr_wdata,
   output logic [2:0]                rsp_machine_state,
   output logic [3:0]                rsp_transitions,
   output logic [3:0]                rsp_frames_sent,
   output logic                      rsp_ntt_pending,
   output logic                      rsp_tx_opportunity
);

   localparam int TRANS_W = $clog2(MAX_LOOP + 1);

   // Configuration registers.
   logic [1:0]            ver_ff;
   logic [7:0]            txlim_ff;
   logic [15:0]           lint_ff, fast_ff, slow_ff;

   // Machine state and per-item counters.
   lacp_tsm_pkg::item_type item_ff;
   logic [2:0]            st_ff;
   logic                  ntt_ff;
   logic [7:0]            sent_ff;
   logic [TIMER_BITS-1:0] lim_ff, per_ff;
   logic [TRANS_W-1:0]    trans_ff, frames_ff;

   // Result register.
   logic [2:0]            out_state_ff;
   logic [3:0]            out_trans_ff, out_frames_ff;
   logic                  out_ntt_ff, out_opp_ff;

   // Step logic.
   logic                  v1, en, short_to, global_off, opp;
   logic [TIMER_BITS-1:0] lim_load, fast_load, slow_load, lim_pre;
   logic [7:0]            sent_pre, sent_inc;
   logic                  go_nt, go_rc, go_pdu, go_fast, go_slow, fired, frame;
   logic [2:0]            st_s;
   logic                  ntt_s;
   logic [7:0]            sent_s;
   logic [TIMER_BITS-1:0] lim_s, per_s;

   assign v1         = (ver_ff == lacp_tsm_pkg::PROTOCOL_V1);
   assign en         = item_ff.tx_enabled;
   assign short_to   = item_ff.partner_short_timeout;
   assign global_off = !item_ff.port_up || !item_ff.point_to_point ||
                       (!item_ff.actor_active && !item_ff.partner_active);
   assign lim_load   = TIMER_BITS'(lint_ff);
   assign fast_load  = TIMER_BITS'(fast_ff);
   assign slow_load  = TIMER_BITS'(slow_ff);

   // Version 2 restarts the rate-limit interval at the top of a step once the limit timer is zero.
   assign lim_pre  = (!v1 && (lim_ff == '0)) ? lim_load : lim_ff;
   assign sent_pre = (!v1 && (lim_ff == '0)) ? 8'd0 : sent_ff;
   assign sent_inc = (sent_pre == lacp_tsm_pkg::SENT_MAX) ? sent_pre : sent_pre + 8'd1;
   assign opp      = (sent_pre <= txlim_ff);

   // Transition selection.
   always_comb begin
      go_nt   = 1'b0;
      go_rc   = 1'b0;
      go_pdu  = 1'b0;
      go_fast = 1'b0;
      go_slow = 1'b0;
      if (v1) begin
         if ((st_ff != lacp_tsm_pkg::ST_NO_TX) && !en) begin
            go_nt = 1'b1;
         end else begin
            case (st_ff)
               lacp_tsm_pkg::ST_NO_TX: begin
                  if (!en && ntt_ff) go_nt = 1'b1;
                  else if (en) go_rc = 1'b1;
               end
               lacp_tsm_pkg::ST_RESET_COUNT: begin
                  if (ntt_ff) go_pdu = 1'b1;
               end
               lacp_tsm_pkg::ST_TX_PDU: begin
                  if (ntt_ff && (sent_ff < txlim_ff)) go_pdu = 1'b1;
                  else if (lim_ff == '0) go_rc = 1'b1;
               end
               default: begin
                  go_nt = 1'b1;
               end
            endcase
         end
      end else begin
         if (global_off) begin
            if (st_ff != lacp_tsm_pkg::ST_NO_TX) go_nt = 1'b1;
         end else begin
            case (st_ff)
               lacp_tsm_pkg::ST_NO_TX: begin
                  if (short_to) go_fast = 1'b1;
                  else go_slow = 1'b1;
               end
               lacp_tsm_pkg::ST_FAST: begin
                  if ((ntt_ff || (per_ff == '0)) && opp) go_pdu = 1'b1;
                  else if (!ntt_ff && (per_ff != '0) && !short_to) go_slow = 1'b1;
               end
               lacp_tsm_pkg::ST_SLOW: begin
                  if ((ntt_ff || (per_ff == '0) || short_to) && opp) go_pdu = 1'b1;
               end
               default: begin
                  go_nt = 1'b1;
               end
            endcase
         end
      end
   end

   assign fired = go_nt || go_rc || go_pdu || go_fast || go_slow;
   assign frame = go_pdu && item_ff.mac_up;

   // Entry actions of the selected state.
   always_comb begin
      st_s   = st_ff;
      ntt_s  = ntt_ff;
      sent_s = sent_pre;
      lim_s  = lim_pre;
      per_s  = per_ff;
      if (go_nt) begin
         st_s = lacp_tsm_pkg::ST_NO_TX;
         if (v1) begin
            ntt_s  = 1'b0;
            sent_s = 8'd0;
            lim_s  = '0;
         end else begin
            per_s = '0;
         end
      end
      if (go_rc) begin
         st_s   = lacp_tsm_pkg::ST_RESET_COUNT;
         sent_s = 8'd0;
      end
      if (go_pdu) begin
         if (v1) begin
            st_s = lacp_tsm_pkg::ST_TX_PDU;
            if (item_ff.mac_up) begin
               ntt_s = 1'b0;
               if (lim_ff == '0) begin
                  lim_s  = lim_load;
                  sent_s = 8'd1;
               end else begin
                  sent_s = sent_inc;
               end
            end
         end else begin
            // A version 2 frame goes straight on to periodic sending.
            ntt_s  = 1'b0;
            sent_s = sent_inc;
            if (short_to) begin
               st_s  = lacp_tsm_pkg::ST_FAST;
               per_s = fast_load;
            end else begin
               st_s  = lacp_tsm_pkg::ST_SLOW;
               per_s = slow_load;
            end
         end
      end
      if (go_fast) begin
         st_s  = lacp_tsm_pkg::ST_FAST;
         per_s = fast_load;
      end
      if (go_slow) begin
         st_s  = lacp_tsm_pkg::ST_SLOW;
         per_s = slow_load;
      end
   end

   assign status.mode       = item_ff.mode;
   assign status.single     = item_ff.single_step;
   assign status.fired      = fired;
   assign status.trans_last = (trans_ff == TRANS_W'(MAX_LOOP - 1));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ver_ff   <= lacp_tsm_pkg::RST_PROTOCOL_VERSION;
         txlim_ff <= lacp_tsm_pkg::RST_TX_LIMIT;
         lint_ff  <= lacp_tsm_pkg::RST_LIMIT_INTERVAL;
         fast_ff  <= lacp_tsm_pkg::RST_FAST_PERIOD;
         slow_ff  <= lacp_tsm_pkg::RST_SLOW_PERIOD;
      end else if (csr_write) begin
         unique case (csr_index)
            lacp_tsm_pkg::CSR_PROTOCOL_VERSION: ver_ff   <= csr_wdata[1:0];
            lacp_tsm_pkg::CSR_TX_LIMIT:         txlim_ff <= csr_wdata[7:0];
            lacp_tsm_pkg::CSR_LIMIT_INTERVAL:   lint_ff  <= csr_wdata;
            lacp_tsm_pkg::CSR_FAST_PERIOD:      fast_ff  <= csr_wdata;
            lacp_tsm_pkg::CSR_SLOW_PERIOD:      slow_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Machine state, timers and per-item counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= lacp_tsm_pkg::ST_NO_TX;
         ntt_ff    <= 1'b0;
         sent_ff   <= 8'd0;
         lim_ff    <= '0;
         per_ff    <= '0;
         trans_ff  <= '0;
         frames_ff <= '0;
      end else if (cmd.capture) begin
         trans_ff  <= '0;
         frames_ff <= '0;
         if ((item.mode == lacp_tsm_pkg::MODE_EVAL) && item.ntt_request) ntt_ff <= 1'b1;
      end else if (cmd.exec) begin
         case (item_ff.mode)
            lacp_tsm_pkg::MODE_EVAL: begin
               st_ff     <= st_s;
               ntt_ff    <= ntt_s;
               sent_ff   <= sent_s;
               lim_ff    <= lim_s;
               per_ff    <= per_s;
               trans_ff  <= trans_ff + TRANS_W'(fired);
               frames_ff <= frames_ff + TRANS_W'(frame);
            end
            lacp_tsm_pkg::MODE_TICK: begin
               if (lim_ff != '0) lim_ff <= lim_ff - TIMER_BITS'(1);
               if (per_ff != '0) per_ff <= per_ff - TIMER_BITS'(1);
            end
            lacp_tsm_pkg::MODE_RESET: begin
               st_ff   <= lacp_tsm_pkg::ST_NO_TX;
               sent_ff <= 8'd0;
               lim_ff  <= '0;
               if (v1) ntt_ff <= 1'b0;
               else per_ff <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Item capture and result register.
   always_ff @(posedge clock) begin
      if (cmd.capture) item_ff <= item;
      if (cmd.load_out) begin
         out_state_ff  <= st_ff;
         out_trans_ff  <= 4'(trans_ff);
         out_frames_ff <= 4'(frames_ff);
         out_ntt_ff    <= ntt_ff;
         out_opp_ff    <= !v1 && (sent_ff <= txlim_ff);
      end
   end

   assign rsp_machine_state  = out_state_ff;
   assign rsp_transitions    = out_trans_ff;
   assign rsp_frames_sent    = out_frames_ff;
   assign rsp_ntt_pending    = out_ntt_ff;
   assign rsp_tx_opportunity = out_opp_ff;

endmodule

/* tb/sv/lacp_tx_checker.sv */
// Checker that predicts every result beat of the transmit machine and compares it.
`timescale 1ns / 1ps
module lacp_tx_checker #(
   parameter int EVAL_BOUND = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic        req_single_step,
   input  logic        req_ntt_request,
   input  logic        req_tx_enabled,
   input  logic        req_port_up,
   input  logic        req_point_to_point,
   input  logic        req_actor_active,
   input  logic        req_partner_active,
   input  logic        req_partner_short_timeout,
   input  logic        req_mac_up,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_machine_state,
   input  logic [3:0]  rsp_transitions,
   input  logic [3:0]  rsp_frames_sent,
   input  logic        rsp_ntt_pending,
   input  logic        rsp_tx_opportunity,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          failures,
   output int          outstanding,
   output int          compared
);

   typedef struct packed {
      logic [2:0] machine_state;
      logic [3:0] transitions;
      logic [3:0] frames_sent;
      logic       ntt_pending;
      logic       tx_opportunity;
   } outcome_type;

   // Register copy.
   logic [1:0]  cfg_version;
   logic [7:0]  cfg_tx_limit;
   logic [15:0] cfg_limit_interval;
   logic [15:0] cfg_fast_period;
   logic [15:0] cfg_slow_period;

   // Machine copy.
   logic [2:0]  mach_state;
   logic        ntt_flag;
   logic [7:0]  sent_count;
   logic [15:0] limit_timer;
   logic [15:0] periodic_timer;
   int          frame_tally;

   outcome_type pending_outcomes[$];

   function automatic logic [2:0] enter_no_tx();
      if (cfg_version == lacp_tsm_pkg::PROTOCOL_V1) begin
         ntt_flag = 1'b0;
         sent_count = '0;
         limit_timer = '0;
      end else begin
         periodic_timer = '0;
      end
      return lacp_tsm_pkg::ST_NO_TX;
   endfunction

   function automatic logic [2:0] enter_periodic(logic fast);
      periodic_timer = fast ? cfg_fast_period : cfg_slow_period;
      return fast ? lacp_tsm_pkg::ST_FAST : lacp_tsm_pkg::ST_SLOW;
   endfunction

   function automatic logic [2:0] enter_reset_count();
      sent_count = '0;
      return lacp_tsm_pkg::ST_RESET_COUNT;
   endfunction

   function automatic void bump_sent();
      if (sent_count != lacp_tsm_pkg::SENT_MAX) sent_count++;
   endfunction

   // Under version 1 a frame that cannot go out leaves the flag and counters alone;
   // under version 2 the count and the flag move whether or not the MAC is up.
   function automatic logic [2:0] enter_tx_pdu(lacp_tsm_pkg::item_type it);
      if (cfg_version == lacp_tsm_pkg::PROTOCOL_V1) begin
         if (it.mac_up) begin
            frame_tally++;
            ntt_flag = 1'b0;
            if (limit_timer == '0) begin
               limit_timer = cfg_limit_interval;
               sent_count = 8'd1;
            end else begin
               bump_sent();
            end
         end
         return lacp_tsm_pkg::ST_TX_PDU;
      end
      if (it.mac_up) frame_tally++;
      bump_sent();
      ntt_flag = 1'b0;
      return enter_periodic(it.partner_short_timeout);
   endfunction

   // One pass over the transition conditions; returns whether a transition fired.
   function automatic logic machine_step(lacp_tsm_pkg::item_type it);
      logic       ntt;
      logic       opp;
      logic       link_down;
      logic       fired;
      logic [2:0] nxt;
      ntt = ntt_flag;
      fired = 1'b1;
      nxt = mach_state;
      if (cfg_version == lacp_tsm_pkg::PROTOCOL_V1) begin
         if (mach_state != lacp_tsm_pkg::ST_NO_TX && !it.tx_enabled) begin
            nxt = enter_no_tx();
         end else if (mach_state == lacp_tsm_pkg::ST_NO_TX) begin
            if (!it.tx_enabled && ntt) nxt = enter_no_tx();
            else if (it.tx_enabled) nxt = enter_reset_count();
            else fired = 1'b0;
         end else if (mach_state == lacp_tsm_pkg::ST_RESET_COUNT) begin
            if (ntt) nxt = enter_tx_pdu(it);
            else fired = 1'b0;
         end else if (mach_state == lacp_tsm_pkg::ST_TX_PDU) begin
            if (ntt && sent_count < cfg_tx_limit) nxt = enter_tx_pdu(it);
            else if (limit_timer == '0) nxt = enter_reset_count();
            else fired = 1'b0;
         end else begin
            nxt = enter_no_tx();
         end
      end else begin
         if (limit_timer == '0) begin
            limit_timer = cfg_limit_interval;
            sent_count = '0;
         end
         opp = sent_count <= cfg_tx_limit;
         link_down = !it.port_up || !it.point_to_point ||
                     (!it.actor_active && !it.partner_active);
         if (link_down) begin
            if (mach_state != lacp_tsm_pkg::ST_NO_TX) nxt = enter_no_tx();
            else fired = 1'b0;
         end else if (mach_state == lacp_tsm_pkg::ST_NO_TX) begin
            nxt = enter_periodic(it.partner_short_timeout);
         end else if (mach_state == lacp_tsm_pkg::ST_FAST) begin
            if ((ntt || periodic_timer == '0) && opp) begin
               nxt = enter_tx_pdu(it);
            end else if (!ntt && periodic_timer != '0 && !it.partner_short_timeout) begin
               nxt = enter_periodic(1'b0);
            end else begin
               fired = 1'b0;
            end
         end else if (mach_state == lacp_tsm_pkg::ST_SLOW) begin
            if ((ntt || periodic_timer == '0 || it.partner_short_timeout) && opp) begin
               nxt = enter_tx_pdu(it);
            end else begin
               fired = 1'b0;
            end
         end else begin
            nxt = enter_no_tx();
         end
      end
      mach_state = nxt;
      return fired;
   endfunction

   function automatic outcome_type predict_outcome(lacp_tsm_pkg::item_type it);
      outcome_type res;
      int          steps;
      steps = 0;
      frame_tally = 0;
      case (it.mode)
         lacp_tsm_pkg::MODE_EVAL: begin
            if (it.ntt_request) ntt_flag = 1'b1;
            while (steps < EVAL_BOUND && machine_step(it)) begin
               steps++;
               if (it.single_step) break;
            end
         end
         lacp_tsm_pkg::MODE_TICK: begin
            if (limit_timer != '0) limit_timer--;
            if (periodic_timer != '0) periodic_timer--;
         end
         lacp_tsm_pkg::MODE_RESET: begin
            mach_state = enter_no_tx();
            limit_timer = '0;
            sent_count = '0;
         end
         default: ;
      endcase
      res.machine_state = mach_state;
      res.transitions = 4'(steps);
      res.frames_sent = 4'(frame_tally);
      res.ntt_pending = ntt_flag;
      res.tx_opportunity = (cfg_version != lacp_tsm_pkg::PROTOCOL_V1) &&
                           (sent_count <= cfg_tx_limit);
      return res;
   endfunction

   task automatic check_field(input string label, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      lacp_tsm_pkg::item_type it;
      outcome_type            want;
      if (reset) begin
         cfg_version = lacp_tsm_pkg::RST_PROTOCOL_VERSION;
         cfg_tx_limit = lacp_tsm_pkg::RST_TX_LIMIT;
         cfg_limit_interval = lacp_tsm_pkg::RST_LIMIT_INTERVAL;
         cfg_fast_period = lacp_tsm_pkg::RST_FAST_PERIOD;
         cfg_slow_period = lacp_tsm_pkg::RST_SLOW_PERIOD;
         mach_state = lacp_tsm_pkg::ST_NO_TX;
         ntt_flag = 1'b0;
         sent_count = '0;
         limit_timer = '0;
         periodic_timer = '0;
         pending_outcomes.delete();
         failures = 0;
         compared = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               lacp_tsm_pkg::CSR_PROTOCOL_VERSION: cfg_version = csr_wdata[1:0];
               lacp_tsm_pkg::CSR_TX_LIMIT:         cfg_tx_limit = csr_wdata[7:0];
               lacp_tsm_pkg::CSR_LIMIT_INTERVAL:   cfg_limit_interval = csr_wdata;
               lacp_tsm_pkg::CSR_FAST_PERIOD:      cfg_fast_period = csr_wdata;
               lacp_tsm_pkg::CSR_SLOW_PERIOD:      cfg_slow_period = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            it.mode = req_mode;
            it.single_step = req_single_step;
            it.ntt_request = req_ntt_request;
            it.tx_enabled = req_tx_enabled;
            it.port_up = req_port_up;
            it.point_to_point = req_point_to_point;
            it.actor_active = req_actor_active;
            it.partner_active = req_partner_active;
            it.partner_short_timeout = req_partner_short_timeout;
            it.mac_up = req_mac_up;
            pending_outcomes.push_back(predict_outcome(it));
         end
         if (rsp_valid && !rsp_stall) begin
            compared++;
            if (pending_outcomes.size() == 0) begin
               $display("%0t: unexpected result beat, state %0d transitions %0d frames %0d",
                        $time, rsp_machine_state, rsp_transitions, rsp_frames_sent);
               failures++;
            end else begin
               want = pending_outcomes.pop_front();
               check_field("machine_state", want.machine_state, rsp_machine_state);
               check_field("transitions", want.transitions, rsp_transitions);
               check_field("frames_sent", want.frames_sent, rsp_frames_sent);
               check_field("ntt_pending", want.ntt_pending, rsp_ntt_pending);
               check_field("tx_opportunity", want.tx_opportunity, rsp_tx_opportunity);
            end
         end
      end
      outstanding = pending_outcomes.size();
   end

endmodule

/* tb/sv/tb_top.sv */
// Top of the transmit machine testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps
module tb_top;

   // Mode 3 has no meaning; the block must report its state and do nothing else.
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   // Version codes other than 1 all select the periodic machine.
   localparam logic [1:0] VERSION_ZERO  = 2'd0;
   localparam logic [1:0] VERSION_TWO   = 2'd2;
   localparam logic [1:0] VERSION_THREE = 2'd3;

   localparam logic [1:0] MODE_EVAL  = lacp_tsm_pkg::MODE_EVAL;
   localparam logic [1:0] MODE_TICK  = lacp_tsm_pkg::MODE_TICK;
   localparam logic [1:0] MODE_RESET = lacp_tsm_pkg::MODE_RESET;

   localparam int PHASES       = 15;
   localparam int PHASE_BEATS  = 100;
   localparam int SQUEEZE      = 30;   // beats offered back to back during a hold-off
   localparam int HOLD_CYCLES  = 250;  // length of a long receiver hold-off
   localparam int SETTLE       = 20;   // a little more than the longest evaluation

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_mode;
   logic        req_single_step;
   logic        req_ntt_request;
   logic        req_tx_enabled;
   logic        req_port_up;
   logic        req_point_to_point;
   logic        req_actor_active;
   logic        req_partner_active;
   logic        req_partner_short_timeout;
   logic        req_mac_up;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_machine_state;
   logic [3:0]  rsp_transitions;
   logic [3:0]  rsp_frames_sent;
   logic        rsp_ntt_pending;
   logic        rsp_tx_opportunity;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   int failures;
   int outstanding;
   int compared;

   // Knobs shared between the stimulus and the receiver process. A hold-off is
   // pending while the stimulus has asked for more of them than the receiver has done.
   logic req_idle;
   logic rsp_idle;
   int   holds_asked;
   int   holds_done;

   // Beat tallies for the closing summary.
   int n_eval, n_tick, n_reset, n_unused, n_settings;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   lacp_transmit_state_machine dut (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_stall                 (req_stall),
      .req_mode                  (req_mode),
      .req_single_step           (req_single_step),
      .req_ntt_request           (req_ntt_request),
      .req_tx_enabled            (req_tx_enabled),
      .req_port_up               (req_port_up),
      .req_point_to_point        (req_point_to_point),
      .req_actor_active          (req_actor_active),
      .req_partner_active        (req_partner_active),
      .req_partner_short_timeout (req_partner_short_timeout),
      .req_mac_up                (req_mac_up),
      .rsp_valid                 (rsp_valid),
      .rsp_stall                 (rsp_stall),
      .rsp_machine_state         (rsp_machine_state),
      .rsp_transitions           (rsp_transitions),
      .rsp_frames_sent           (rsp_frames_sent),
      .rsp_ntt_pending           (rsp_ntt_pending),
      .rsp_tx_opportunity        (rsp_tx_opportunity),
      .csr_write                 (csr_write),
      .csr_index                 (csr_index),
      .csr_wdata                 (csr_wdata)
   );

   lacp_tx_checker chk (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_stall                 (req_stall),
      .req_mode                  (req_mode),
      .req_single_step           (req_single_step),
      .req_ntt_request           (req_ntt_request),
      .req_tx_enabled            (req_tx_enabled),
      .req_port_up               (req_port_up),
      .req_point_to_point        (req_point_to_point),
      .req_actor_active          (req_actor_active),
      .req_partner_active        (req_partner_active),
      .req_partner_short_timeout (req_partner_short_timeout),
      .req_mac_up                (req_mac_up),
      .rsp_valid                 (rsp_valid),
      .rsp_stall                 (rsp_stall),
      .rsp_machine_state         (rsp_machine_state),
      .rsp_transitions           (rsp_transitions),
      .rsp_frames_sent           (rsp_frames_sent),
      .rsp_ntt_pending           (rsp_ntt_pending),
      .rsp_tx_opportunity        (rsp_tx_opportunity),
      .csr_write                 (csr_write),
      .csr_index                 (csr_index),
      .csr_wdata                 (csr_wdata),
      .failures                  (failures),
      .outstanding               (outstanding),
      .compared                  (compared)
   );

   // Most gaps are zero or a few cycles; about one in ten is a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Timer lengths are kept short so that ticks actually run the timers out,
   // with the occasional zero, one or full-scale value mixed in.
   function automatic logic [15:0] pick_period(input int longest);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'd0;
      if (r == 1) return 16'hFFFF;
      if (r == 2) return 16'd1;
      return 16'($urandom_range(2, longest));
   endfunction

   function automatic logic [7:0] pick_limit();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return 8'd0;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(1, 6));
   endfunction

   // Conditions lean toward a healthy link so that the machine gets past no_tx
   // and into the sending states; the rest of the beats take it back down.
   function automatic lacp_tsm_pkg::item_type random_beat();
      lacp_tsm_pkg::item_type it;
      int                     r;
      r = $urandom_range(0, 99);
      if (r < 55) it.mode = MODE_EVAL;
      else if (r < 85) it.mode = MODE_TICK;
      else if (r < 94) it.mode = MODE_RESET;
      else it.mode = MODE_UNUSED;
      it.single_step = ($urandom_range(0, 3) == 0);
      it.ntt_request = ($urandom_range(0, 4) < 2);
      it.tx_enabled = ($urandom_range(0, 7) != 0);
      it.port_up = ($urandom_range(0, 9) != 0);
      it.point_to_point = ($urandom_range(0, 9) != 0);
      it.actor_active = ($urandom_range(0, 3) != 0);
      it.partner_active = 1'($urandom_range(0, 1));
      it.partner_short_timeout = 1'($urandom_range(0, 1));
      it.mac_up = ($urandom_range(0, 7) != 0);
      return it;
   endfunction

   // Offers one beat after an optional gap and returns once it has been taken.
   // Valid stays high into the next call when no gap follows.
   task automatic send_beat(input lacp_tsm_pkg::item_type it, input int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_mode = it.mode;
      req_single_step = it.single_step;
      req_ntt_request = it.ntt_request;
      req_tx_enabled = it.tx_enabled;
      req_port_up = it.port_up;
      req_point_to_point = it.point_to_point;
      req_actor_active = it.actor_active;
      req_partner_active = it.partner_active;
      req_partner_short_timeout = it.partner_short_timeout;
      req_mac_up = it.mac_up;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      case (it.mode)
         MODE_EVAL:  n_eval++;
         MODE_TICK:  n_tick++;
         MODE_RESET: n_reset++;
         default:    n_unused++;
      endcase
   endtask

   // Stops offering beats and waits until every predicted result has been seen,
   // then lets the block settle before anything else happens.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      wait (outstanding == 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = index;
      csr_wdata = value;
   endtask

   // Rewrites all five registers; only called while the block is idle.
   task automatic apply_setting(input logic [1:0] version, input logic [7:0] tx_limit,
                                input logic [15:0] interval, input logic [15:0] fast,
                                input logic [15:0] slow);
      write_reg(lacp_tsm_pkg::CSR_PROTOCOL_VERSION, {14'd0, version});
      write_reg(lacp_tsm_pkg::CSR_TX_LIMIT, {8'd0, tx_limit});
      write_reg(lacp_tsm_pkg::CSR_LIMIT_INTERVAL, interval);
      write_reg(lacp_tsm_pkg::CSR_FAST_PERIOD, fast);
      write_reg(lacp_tsm_pkg::CSR_SLOW_PERIOD, slow);
      @(negedge clock);
      csr_write = 1'b0;
      n_settings++;
   endtask

   // Receiver side. Short random stalls while idling is on, and a long hold-off
   // whenever the stimulus asks for one. The hold-off is timed here, so the
   // sender keeps offering beats and the block has to back up into its input.
   initial begin
      int span;
      rsp_stall = 1'b0;
      holds_done = 0;
      forever begin
         @(negedge clock);
         if (holds_asked != holds_done) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall = 1'b0;
            holds_done++;
         end else if (rsp_idle && $urandom_range(0, 5) == 0) begin
            span = 1 + pick_gap();
            rsp_stall = 1'b1;
            repeat (span) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   // A correct run ends well before this timeout.
   initial begin
      #8ms;
      $display("timeout waiting for the block");
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic quiet;
      logic [1:0] version;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_EVAL;
      req_single_step = 1'b0;
      req_ntt_request = 1'b0;
      req_tx_enabled = 1'b0;
      req_port_up = 1'b0;
      req_point_to_point = 1'b0;
      req_actor_active = 1'b0;
      req_partner_active = 1'b0;
      req_partner_short_timeout = 1'b0;
      req_mac_up = 1'b0;
      csr_write = 1'b0;
      csr_index = lacp_tsm_pkg::CSR_PROTOCOL_VERSION;
      csr_wdata = '0;
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      holds_asked = 0;
      n_eval = 0;
      n_tick = 0;
      n_reset = 0;
      n_unused = 0;
      n_settings = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. The flag columns are, left to right: single_step,
      // ntt_request, tx_enabled, port_up, point_to_point, actor_active,
      // partner_active, partner_short_timeout, mac_up.
      // Reset configuration: version 1, three frames per one-tick interval.
      send_beat(lacp_tsm_pkg::item_type'({MODE_UNUSED, 9'b1_1_1_1_1_1_1_1_1}), 0);
      send_beat(lacp_tsm_pkg::item_type'({MODE_TICK,   9'b0_0_0_0_0_0_0_0_0}), 0);
      send_beat(lacp_tsm_pkg::item_type'({MODE_EVAL,   9'b0_0_0_0_0_0_0_0_0}), 0);
      // Enable plus a request walks no_tx, reset_count and tx_pdu in one beat.
      send_beat(lacp_tsm_pkg::item_type'({MODE_EVAL,   9'b0_1_1_0_0_0_0_0_1}), 0);
      send_beat(lacp_tsm_pkg::item_type'({MODE_EVAL,   9'b1_1_1_0_0_0_0_0_1}), 0);
      send_beat(lacp_tsm_pkg::item_type'({MODE_EVAL,   9'b0_1_1_0_0_0_0_0_1}), 0);
      // The rate limit is reached, so the request has to stay pending.
      send_beat(lacp_tsm_pkg::item_type'({MODE_EVAL,   9'b0_1_1_0_0_0_0_0_1}), 0);
      send_beat(lacp_tsm_pkg::item_type'({MODE_TICK,   9'b0_0_0_0_0_0_0_0_0}), 0);
      send_beat(lacp_tsm_pkg::item_type'({MODE_EVAL,   9'b0_0_1_0_0_0_0_0_1}), 0);
      // MAC down keeps the request alive, so tx_pdu repeats until the loop bound.
      send_beat(lacp_tsm_pkg::item_type'({MODE_EVAL,   9'b0_1_1_0_0_0_0_0_0}), 0);
      send_beat(lacp_tsm_pkg::item_type'({MODE_EVAL,   9'b0_1_0_0_0_0_0_0_1}), 0);
      send_beat(lacp_tsm_pkg::item_type'({MODE_EVAL,   9'b0_1_0_0_0_0_0_0_1}), 0);
      send_beat(lacp_tsm_pkg::item_type'({MODE_RESET,  9'b1_1_1_1_1_1_1_1_1}), 0);
      drain();

      // Version 2, widest rate limit and a zero fast period: a healthy link with a
      // short-timeout partner sends fast frames back to back up to the loop bound.
      apply_setting(VERSION_TWO, 8'hFF, 16'd2, 16'd0, 16'd3);
      send_beat(lacp_tsm_pkg::item_type'({MODE_EVAL,   9'b0_0_0_1_1_1_0_1_1}), 0);
      send_beat(lacp_tsm_pkg::item_type'({MODE_EVAL,   9'b0_0_0_1_1_1_0_0_1}), 0);
      send_beat(lacp_tsm_pkg::item_type'({MODE_TICK,   9'b0_0_0_0_0_0_0_0_0}), 0);
      send_beat(lacp_tsm_pkg::item_type'({MODE_EVAL,   9'b0_0_1_0_1_1_1_0_1}), 0);
      send_beat(lacp_tsm_pkg::item_type'({MODE_EVAL,   9'b0_0_1_1_1_0_0_0_1}), 0);
      // From no_tx straight to slow periodic, one step only.
      send_beat(lacp_tsm_pkg::item_type'({MODE_EVAL,   9'b1_0_0_1_1_0_1_0_1}), 0);
      // A version 2 frame with the MAC down still counts toward the rate limit and clears the request.
      send_beat(lacp_tsm_pkg::item_type'({MODE_EVAL,   9'b0_1_0_1_1_0_1_0_0}), 0);
      send_beat(lacp_tsm_pkg::item_type'({MODE_RESET,  9'b0_0_0_0_0_0_0_0_0}), 0);
      drain();

      // Version code 0 behaves as version 2; zero limit and interval, full periods.
      apply_setting(VERSION_ZERO, 8'd0, 16'd0, 16'hFFFF, 16'hFFFF);
      send_beat(lacp_tsm_pkg::item_type'({MODE_EVAL,   9'b0_1_0_1_1_1_1_1_1}), 0);
      drain();

      // Back to version 1 while parked in fast periodic: that state means nothing
      // here and must fall back to no_tx before the version 1 path runs.
      apply_setting(lacp_tsm_pkg::PROTOCOL_V1, lacp_tsm_pkg::RST_TX_LIMIT,
                    lacp_tsm_pkg::RST_LIMIT_INTERVAL, lacp_tsm_pkg::RST_FAST_PERIOD,
                    lacp_tsm_pkg::RST_SLOW_PERIOD);
      send_beat(lacp_tsm_pkg::item_type'({MODE_EVAL,   9'b0_1_1_0_0_0_0_0_1}), 0);
      drain();

      // Version code 3, left in tx_pdu, which version 2 does not know either.
      apply_setting(VERSION_THREE, 8'd1, 16'hFFFF, 16'd1, 16'd0);
      send_beat(lacp_tsm_pkg::item_type'({MODE_EVAL,   9'b0_0_0_1_1_1_1_0_1}), 0);
      send_beat(lacp_tsm_pkg::item_type'({MODE_EVAL,   9'b0_1_0_1_1_1_1_0_1}), 0);
      drain();

      // Random part: one register setting per phase, alternating between the two
      // machines, every third phase run without any idling on either side.
      for (int p = 0; p < PHASES; p++) begin
         quiet = (p % 3 == 2);
         req_idle = !quiet;
         rsp_idle = !quiet;
         case (p % 4)
            0, 2:    version = lacp_tsm_pkg::PROTOCOL_V1;
            1:       version = VERSION_TWO;
            default: version = (p == 3) ? VERSION_ZERO : VERSION_THREE;
         endcase
         apply_setting(version, pick_limit(), pick_period(8), pick_period(6),
                       pick_period(20));

         // Twice in the run, the receiver goes away for a long stretch while beats
         // keep coming, so the single item in flight blocks the input side.
         if (p == 1 || p == 8) begin
            holds_asked++;
            repeat (SQUEEZE) send_beat(random_beat(), 0);
         end

         repeat (PHASE_BEATS) send_beat(random_beat(), req_idle ? pick_gap() : 0);
         drain();
      end

      $display("Covered %0d evaluations, %0d ticks, %0d machine resets and %0d unused-mode beats",
               n_eval, n_tick, n_reset, n_unused);
      $display("under %0d register settings with %0d long receiver hold-offs; %0d results checked.",
               n_settings, holds_done, compared);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/lacp_tsm_pkg.sv
rtl/lacp_tsm_ctrl.sv
rtl/lacp_tsm_dp.sv
rtl/lacp_transmit_state_machine.sv
tb/sv/lacp_tx_checker.sv
tb/sv/tb_top.sv
